/* sv/rpg_pkg.sv */
// ============================================================================
// rpg_pkg
// Shared types and constants for the range point to global frame transform:
// CORDIC word format, arctangent steps and the constant-divisor values used
// to turn hundredths of a degree into a binary angle.
// ============================================================================
`default_nettype none

package rpg_pkg;

    // Default and largest number of CORDIC iterations.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_MAX_STEPS = 32;

    // CORDIC datapath word; Q30 values with headroom for growth.
    localparam int CW = 34;
    typedef logic signed [CW-1:0] cw_t;

    // CORDIC start value, 0.6072529350 in Q30.
    localparam cw_t CORDIC_GAIN = 34'sd652032874;

    // One full turn in hundredths of a degree.
    localparam logic [16:0] FULL_TURN_CD = 17'd36000;

    // Binary angle = floor((m * 2^27 + 562) / 1125), with
    // 2^27 = 1125 * 119304 + 728, so the quotient is
    // m * 119304 + floor((m * 728 + 562) / 1125).
    localparam logic [16:0] TURN_STEP_HI = 17'd119304;
    localparam logic [9:0]  TURN_STEP_LO = 10'd728;
    localparam logic [9:0]  TURN_BIAS    = 10'd562;

    // Division by 1125 through a reciprocal multiply and one correction.
    localparam logic [10:0] DIV_CONST = 11'd1125;
    localparam logic [29:0] DIV_RECIP = 30'd977343669;
    localparam int          DIV_SHIFT = 40;

    // Quarter turn as a 32-bit binary angle.
    localparam logic signed [31:0] QUARTER_TURN = 32'sd1073741824;

    // Per-item fields that ride along the pipeline with the angles.
    typedef struct packed {
        logic [15:0]        range_mm;
        logic signed [15:0] mount_x;
        logic signed [15:0] mount_y;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
    } point_sb_t;

    // Rounded arctangent of 2^-idx as a 32-bit binary angle.
    function automatic cw_t atan_step(input int idx);
        cw_t val;
        case (idx)
            0:  val = 34'sd536870912;
            1:  val = 34'sd316933406;
            2:  val = 34'sd167458907;
            3:  val = 34'sd85004756;
            4:  val = 34'sd42667331;
            5:  val = 34'sd21354465;
            6:  val = 34'sd10679838;
            7:  val = 34'sd5340245;
            8:  val = 34'sd2670163;
            9:  val = 34'sd1335087;
            10: val = 34'sd667544;
            11: val = 34'sd333772;
            12: val = 34'sd166886;
            13: val = 34'sd83443;
            14: val = 34'sd41722;
            15: val = 34'sd20861;
            16: val = 34'sd10430;
            17: val = 34'sd5215;
            18: val = 34'sd2608;
            19: val = 34'sd1304;
            20: val = 34'sd652;
            21: val = 34'sd326;
            22: val = 34'sd163;
            23: val = 34'sd81;
            24: val = 34'sd41;
            25: val = 34'sd20;
            26: val = 34'sd10;
            27: val = 34'sd5;
            28: val = 34'sd3;
            29: val = 34'sd1;
            30: val = 34'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* sv/range_point_to_global_frame.sv */
// ============================================================================
// range_point_to_global_frame
// Fully pipelined transform of one range reading into a global-frame point.
// The block accepts one point per clock while point_ready is high. The
// pipeline depth is set by the CORDIC, which spends one register stage per
// iteration, plus five stages that turn both angles into binary angles and
// five stages of multiplies and adds. Beam and heading run through the
// CORDIC side by side in two lanes. Results land in a two-entry output
// buffer, so point_ready drops only while both entries hold results that
// have not been taken.
// ============================================================================
`default_nettype none

module range_point_to_global_frame
    import rpg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               point_valid,
    output logic               point_ready,
    input  logic [15:0]        range_mm,
    input  logic signed [15:0] beam_angle,
    input  logic signed [15:0] mount_x,
    input  logic signed [15:0] mount_y,
    input  logic signed [15:0] heading,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,

    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] global_x,
    output logic signed [31:0] global_y
);

    localparam int NL        = 2;
    localparam int LANE_BEAM = 0;
    localparam int LANE_HEAD = 1;
    localparam logic [1:0] BUF_DEPTH = 2'd2;

    // Pipeline advance; every stage moves together.
    logic adv;

    // Stage A: angles reduced into one turn.
    logic               a_vld_reg;
    point_sb_t          a_sb_reg;
    logic [15:0]        a_m_reg  [NL];
    logic [15:0]        a_m_next [NL];
    logic signed [15:0] angle_in [NL];

    // Stage B: split product for the binary angle.
    logic               b_vld_reg;
    point_sb_t          b_sb_reg;
    logic [24:0]        b_num_reg  [NL];
    logic [24:0]        b_num_next [NL];
    logic [31:0]        b_base_reg  [NL];
    logic [31:0]        b_base_next [NL];

    // Stage C: quotient estimate by reciprocal multiply.
    logic               c_vld_reg;
    point_sb_t          c_sb_reg;
    logic [24:0]        c_num_reg  [NL];
    logic [31:0]        c_base_reg [NL];
    logic [14:0]        c_qest_reg [NL];
    logic [54:0]        c_prod     [NL];

    // Stage D: corrected binary angle.
    logic               d_vld_reg;
    point_sb_t          d_sb_reg;
    logic [31:0]        d_z_reg  [NL];
    logic [31:0]        d_z_next [NL];
    logic [24:0]        d_rem    [NL];

    // Half-turn fold in front of the CORDIC.
    logic [31:0]        e_z_fold [NL];
    logic [NL-1:0]      e_neg;

    // CORDIC stages; index 0 is the loaded start value.
    logic               cv_reg   [CORDIC_STEPS+1];
    point_sb_t          csb_reg  [CORDIC_STEPS+1];
    logic [NL-1:0]      cneg_reg [CORDIC_STEPS+1];
    cw_t                cx_reg   [CORDIC_STEPS+1][NL];
    cw_t                cy_reg   [CORDIC_STEPS+1][NL];
    cw_t                cz_reg   [CORDIC_STEPS+1][NL];
    cw_t                cx_next  [CORDIC_STEPS][NL];
    cw_t                cy_next  [CORDIC_STEPS][NL];
    cw_t                cz_next  [CORDIC_STEPS][NL];

    // Stage N: signs restored.
    logic               n_vld_reg;
    point_sb_t          n_sb_reg;
    cw_t                n_cos_reg [NL];
    cw_t                n_sin_reg [NL];

    // Stage M1: beam products.
    logic               m1_vld_reg;
    point_sb_t          m1_sb_reg;
    logic signed [50:0] m1_pbx_reg;
    logic signed [50:0] m1_pby_reg;
    cw_t                m1_cos_reg;
    cw_t                m1_sin_reg;

    // Stage M2: robot-frame point in Q14.
    logic               m2_vld_reg;
    point_sb_t          m2_sb_reg;
    logic signed [32:0] m2_xq_reg;
    logic signed [32:0] m2_yq_reg;
    cw_t                m2_cos_reg;
    cw_t                m2_sin_reg;
    logic signed [51:0] m2_sum_x;
    logic signed [51:0] m2_sum_y;

    // Stage M3: rotation products.
    logic               m3_vld_reg;
    point_sb_t          m3_sb_reg;
    logic signed [66:0] m3_xc_reg;
    logic signed [66:0] m3_ys_reg;
    logic signed [66:0] m3_xs_reg;
    logic signed [66:0] m3_yc_reg;

    // Stage M4: rotated point in Q44.
    logic               m4_vld_reg;
    point_sb_t          m4_sb_reg;
    logic signed [67:0] m4_rx_reg;
    logic signed [67:0] m4_ry_reg;

    // Placement and saturation.
    logic signed [33:0] place_x;
    logic signed [33:0] place_y;
    logic signed [31:0] sat_x;
    logic signed [31:0] sat_y;

    // Output buffer.
    logic [1:0]         buf_cnt_reg;
    logic [1:0]         buf_cnt_next;
    logic signed [31:0] buf_x_reg [BUF_DEPTH];
    logic signed [31:0] buf_y_reg [BUF_DEPTH];
    logic               push;
    logic               pop;
    logic               wr_hi;

    // Handshake and pipeline enable.
    assign adv          = (buf_cnt_reg != BUF_DEPTH);
    assign point_ready  = adv;
    assign result_valid = (buf_cnt_reg != 2'd0);
    assign global_x     = buf_x_reg[0];
    assign global_y     = buf_y_reg[0];

    assign angle_in[LANE_BEAM] = beam_angle;
    assign angle_in[LANE_HEAD] = heading;

    // Angle prep: wrap, split multiply, quotient estimate, correction and half-turn fold.
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (angle_in[l][15])
                a_m_next[l] = 16'(17'(angle_in[l]) + FULL_TURN_CD);
            else
                a_m_next[l] = $unsigned(angle_in[l]);

            b_num_next[l]  = 25'(a_m_reg[l]) * 25'(TURN_STEP_LO) + 25'(TURN_BIAS);
            b_base_next[l] = 32'(a_m_reg[l]) * 32'(TURN_STEP_HI);

            c_prod[l] = 55'(b_num_reg[l]) * 55'(DIV_RECIP);

            d_rem[l]    = c_num_reg[l] - 25'(c_qest_reg[l]) * 25'(DIV_CONST);
            d_z_next[l] = c_base_reg[l] + 32'(c_qest_reg[l])
                        + 32'(d_rem[l] >= 25'(DIV_CONST));

            // Angles past a quarter turn move by half a turn and flip sign.
            e_neg[l] = ($signed(d_z_reg[l]) > QUARTER_TURN)
                    || ($signed(d_z_reg[l]) < -QUARTER_TURN);
            if (e_neg[l])
                e_z_fold[l] = {~d_z_reg[l][31], d_z_reg[l][30:0]};
            else
                e_z_fold[l] = d_z_reg[l];
        end
    end

    // One CORDIC rotation per stage and lane.
    always_comb
    begin
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                if (!cz_reg[k][l][CW-1])
                begin
                    cx_next[k][l] = cx_reg[k][l] - (cy_reg[k][l] >>> k);
                    cy_next[k][l] = cy_reg[k][l] + (cx_reg[k][l] >>> k);
                    cz_next[k][l] = cz_reg[k][l] - atan_step(k);
                end
                else
                begin
                    cx_next[k][l] = cx_reg[k][l] + (cy_reg[k][l] >>> k);
                    cy_next[k][l] = cy_reg[k][l] - (cx_reg[k][l] >>> k);
                    cz_next[k][l] = cz_reg[k][l] + atan_step(k);
                end
            end
        end
    end

    // Robot-frame point, rounded half up to Q14.
    always_comb
    begin
        m2_sum_x = 52'(m1_pbx_reg) + (52'(m1_sb_reg.mount_x) <<< 30) + 52'sd32768;
        m2_sum_y = 52'(m1_pby_reg) + (52'(m1_sb_reg.mount_y) <<< 30) + 52'sd32768;
    end

    // Add the pose with rounding, then saturate to 32 bits.
    always_comb
    begin
        place_x = 34'(m4_sb_reg.pose_x) + 34'($signed(m4_rx_reg[67:44]))
                + 34'(m4_rx_reg[43]);
        place_y = 34'(m4_sb_reg.pose_y) + 34'($signed(m4_ry_reg[67:44]))
                + 34'(m4_ry_reg[43]);

        if (place_x > 34'sd2147483647)
            sat_x = 32'sh7FFFFFFF;
        else if (place_x < -34'sd2147483648)
            sat_x = 32'sh80000000;
        else
            sat_x = place_x[31:0];

        if (place_y > 34'sd2147483647)
            sat_y = 32'sh7FFFFFFF;
        else if (place_y < -34'sd2147483648)
            sat_y = 32'sh80000000;
        else
            sat_y = place_y[31:0];
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            d_vld_reg  <= 1'b0;
            cv_reg     <= '{default: 1'b0};
            n_vld_reg  <= 1'b0;
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= point_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            cv_reg[0] <= d_vld_reg;
            for (int k = 0; k < CORDIC_STEPS; k++)
                cv_reg[k+1] <= cv_reg[k];
            n_vld_reg  <= cv_reg[CORDIC_STEPS];
            m1_vld_reg <= n_vld_reg;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
        end
    end

    // Angle prep payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sb_reg <= '{range_mm: range_mm, mount_x: mount_x, mount_y: mount_y,
                          pose_x: pose_x, pose_y: pose_y};
            a_m_reg    <= a_m_next;
            b_sb_reg   <= a_sb_reg;
            b_num_reg  <= b_num_next;
            b_base_reg <= b_base_next;
            c_sb_reg   <= b_sb_reg;
            c_num_reg  <= b_num_reg;
            c_base_reg <= b_base_reg;
            for (int l = 0; l < NL; l++)
                c_qest_reg[l] <= c_prod[l][DIV_SHIFT +: 15];
            d_sb_reg <= c_sb_reg;
            d_z_reg  <= d_z_next;
        end
    end

    // CORDIC payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            csb_reg[0]  <= d_sb_reg;
            cneg_reg[0] <= e_neg;
            for (int l = 0; l < NL; l++)
            begin
                cx_reg[0][l] <= CORDIC_GAIN;
                cy_reg[0][l] <= '0;
                cz_reg[0][l] <= CW'($signed(e_z_fold[l]));
            end
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                csb_reg[k+1]  <= csb_reg[k];
                cneg_reg[k+1] <= cneg_reg[k];
                cx_reg[k+1]   <= cx_next[k];
                cy_reg[k+1]   <= cy_next[k];
                cz_reg[k+1]   <= cz_next[k];
            end
        end
    end

    // Sign restore, multiplies and rotation payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_sb_reg <= csb_reg[CORDIC_STEPS];
            for (int l = 0; l < NL; l++)
            begin
                if (cneg_reg[CORDIC_STEPS][l])
                begin
                    n_cos_reg[l] <= -cx_reg[CORDIC_STEPS][l];
                    n_sin_reg[l] <= -cy_reg[CORDIC_STEPS][l];
                end
                else
                begin
                    n_cos_reg[l] <= cx_reg[CORDIC_STEPS][l];
                    n_sin_reg[l] <= cy_reg[CORDIC_STEPS][l];
                end
            end

            m1_sb_reg  <= n_sb_reg;
            m1_pbx_reg <= 51'($signed({1'b0, n_sb_reg.range_mm}))
                        * 51'(n_cos_reg[LANE_BEAM]);
            m1_pby_reg <= 51'($signed({1'b0, n_sb_reg.range_mm}))
                        * 51'(n_sin_reg[LANE_BEAM]);
            m1_cos_reg <= n_cos_reg[LANE_HEAD];
            m1_sin_reg <= n_sin_reg[LANE_HEAD];

            m2_sb_reg  <= m1_sb_reg;
            m2_xq_reg  <= m2_sum_x[48:16];
            m2_yq_reg  <= m2_sum_y[48:16];
            m2_cos_reg <= m1_cos_reg;
            m2_sin_reg <= m1_sin_reg;

            m3_sb_reg <= m2_sb_reg;
            m3_xc_reg <= 67'(m2_xq_reg) * 67'(m2_cos_reg);
            m3_ys_reg <= 67'(m2_yq_reg) * 67'(m2_sin_reg);
            m3_xs_reg <= 67'(m2_xq_reg) * 67'(m2_sin_reg);
            m3_yc_reg <= 67'(m2_yq_reg) * 67'(m2_cos_reg);

            m4_sb_reg <= m3_sb_reg;
            m4_rx_reg <= 68'(m3_xc_reg) - 68'(m3_ys_reg);
            m4_ry_reg <= 68'(m3_xs_reg) + 68'(m3_yc_reg);
        end
    end

    // Output buffer control: the head entry is always at slot 0.
    always_comb
    begin
        push  = adv && m4_vld_reg;
        pop   = result_valid && result_ready;
        wr_hi = (buf_cnt_reg == 2'd1) && !pop;
        buf_cnt_next = buf_cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buf_cnt_reg <= 2'd0;
        else
            buf_cnt_reg <= buf_cnt_next;
    end

    // Output buffer data; a push into slot 0 wins over the shift.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf_x_reg[0] <= buf_x_reg[1];
            buf_y_reg[0] <= buf_y_reg[1];
        end
        if (push)
        begin
            if (wr_hi)
            begin
                buf_x_reg[1] <= sat_x;
                buf_y_reg[1] <= sat_y;
            end
            else
            begin
                buf_x_reg[0] <= sat_x;
                buf_y_reg[0] <= sat_y;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/rpg_port_check.sv */
// ============================================================================
// rpg_port_check
// Port-level checks for the range point to global frame transform, bound to
// the top level.
// ============================================================================
`default_nettype none

module rpg_port_check (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               point_ready,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire logic signed [31:0] global_x,
    input wire logic signed [31:0] global_y
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(global_x) && $stable(global_y))
    else $error("result payload changed while stalled");

    // Input backpressure only happens while results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> result_valid)
    else $error("point_ready low with no result pending");

    // Ready drops only after a result was held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(point_ready) |-> $past(result_valid && !result_ready))
    else $error("point_ready fell without a stalled result");

    // Ready returns only after a result transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(point_ready) |-> $past(result_valid && result_ready))
    else $error("point_ready rose without a result transaction");

endmodule

bind range_point_to_global_frame rpg_port_check u_port_check (.*);

`default_nettype wire

/* tb/sv/tb_range_point_to_global_frame.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_range_point_to_global_frame
// Self-checking bench for the range point to global frame transform. A clocked
// driver feeds range readings from a queue, and every accepted transaction is
// run through a local fixed-point model (CORDIC sine and cosine, beam point,
// heading rotation, rounding and saturation). A clocked monitor compares each
// returned global point with the oldest prediction. Directed points cover
// right angles, angle wrap, mount extremes and saturation. Random points
// follow, under three phases of sender and receiver idling.
// ============================================================================

module tb_range_point_to_global_frame
    import rpg_pkg::*;
;

    localparam int     NUM_ITERS    = CORDIC_STEPS_DEF;
    localparam int     PIPE_LATENCY = NUM_ITERS + 10;
    localparam int     DRAIN_CYCLES = 4 * PIPE_LATENCY;
    localparam int     RANDOM_ITEMS = 700;
    localparam longint TURN_CD      = 64'sd36000;
    localparam longint HALF_TURN_CD = 64'sd18000;
    localparam longint BAM_FULL     = 64'sd4294967296;
    localparam longint BAM_HALF     = 64'sd2147483648;
    localparam longint BAM_QUARTER  = 64'sd1073741824;
    localparam longint GAIN_Q30     = 64'sd652032874;
    localparam longint Q30_ONE      = 64'sd1073741824;
    localparam longint HALF_Q16     = 64'sd32768;
    localparam longint FRAC_MASK    = (64'sd1 <<< 44) - 64'sd1;
    localparam longint HALF_ULP     = 64'sd1 <<< 43;
    localparam longint OUT_MAX      = 64'sd2147483647;
    localparam longint OUT_MIN      = -64'sd2147483648;

    // One range reading with the sensor mount and the robot pose.
    typedef struct {
        logic [15:0]        range_mm;
        logic signed [15:0] beam_angle;
        logic signed [15:0] mount_x;
        logic signed [15:0] mount_y;
        logic signed [15:0] heading;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
    } scan_point_t;

    // One global-frame point.
    typedef struct {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
    } global_pt_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        point_valid  = 1'b0;
    logic        point_ready;
    scan_point_t drive_pt     = '{default: '0};
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic signed [31:0] global_x;
    logic signed [31:0] global_y;

    scan_point_t pending_points[$];
    global_pt_t  predicted_globals[$];
    global_pt_t  head_pt;
    int          total_points = 0;
    int          directed_points = 0;
    int          sent_points = 0;
    int          checked_points = 0;
    int          error_count = 0;

    // Rounded arctangent of 2^-i as a 32-bit binary angle.
    longint atan_bam [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    range_point_to_global_frame #(
        .CORDIC_STEPS (NUM_ITERS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .range_mm     (drive_pt.range_mm),
        .beam_angle   (drive_pt.beam_angle),
        .mount_x      (drive_pt.mount_x),
        .mount_y      (drive_pt.mount_y),
        .heading      (drive_pt.heading),
        .pose_x       (drive_pt.pose_x),
        .pose_y       (drive_pt.pose_y),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .global_x     (global_x),
        .global_y     (global_y)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Cosine and sine in Q30 of an angle in hundredths of a degree.
    function automatic void sin_cos_q30(input longint centideg,
                                        output longint cos_v, output longint sin_v);
        longint m;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        m = centideg % TURN_CD;
        if (m < 0)
            m += TURN_CD;
        z = (m * BAM_FULL + HALF_TURN_CD) / TURN_CD;
        if (z >= BAM_HALF)
            z -= BAM_FULL;
        // Angles past a quarter turn are folded by a half turn.
        flip = 1'b0;
        if (z > BAM_QUARTER)
        begin
            z -= BAM_HALF;
            flip = 1'b1;
        end
        else if (z < -BAM_QUARTER)
        begin
            z += BAM_HALF;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < NUM_ITERS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_bam[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_bam[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_v = x;
        sin_v = y;
    endfunction

    // Add a Q44 offset to a pose coordinate, round half up and saturate.
    function automatic logic signed [31:0] place_coord(input longint pose, input longint rot);
        longint t;
        t = pose + (rot >>> 44) + (((rot & FRAC_MASK) >= HALF_ULP) ? 64'sd1 : 64'sd0);
        if (t > OUT_MAX)
            t = OUT_MAX;
        if (t < OUT_MIN)
            t = OUT_MIN;
        return t[31:0];
    endfunction

    // Full transform of one reading into the global frame.
    function automatic global_pt_t transform_point(input scan_point_t p);
        longint     cb;
        longint     sb;
        longint     ch;
        longint     sh;
        longint     rng;
        longint     xq;
        longint     yq;
        global_pt_t g;
        rng = longint'(p.range_mm);
        sin_cos_q30(longint'(p.beam_angle), cb, sb);
        sin_cos_q30(longint'(p.heading), ch, sh);
        xq = (rng * cb + longint'(p.mount_x) * Q30_ONE + HALF_Q16) >>> 16;
        yq = (rng * sb + longint'(p.mount_y) * Q30_ONE + HALF_Q16) >>> 16;
        g.gx = place_coord(longint'(p.pose_x), xq * ch - yq * sh);
        g.gy = place_coord(longint'(p.pose_y), xq * sh + yq * ch);
        return g;
    endfunction

    // Idle percentage for the sender or the receiver in the current phase.
    function automatic int idle_pct(input bit receiver);
        int phase;
        phase = (total_points == 0) ? 0 : (sent_points * 3) / total_points;
        if (phase == 0)
            return receiver ? 61 : 16;
        else if (phase == 1)
            return receiver ? 16 : 61;
        return 0;
    endfunction

    task automatic add_point(input logic [15:0] r, input logic signed [15:0] ba,
                             input logic signed [15:0] mx, input logic signed [15:0] my,
                             input logic signed [15:0] hd, input logic signed [31:0] px,
                             input logic signed [31:0] py);
        scan_point_t p;
        p.range_mm   = r;
        p.beam_angle = ba;
        p.mount_x    = mx;
        p.mount_y    = my;
        p.heading    = hd;
        p.pose_x     = px;
        p.pose_y     = py;
        pending_points.push_back(p);
    endtask

    // Pick an angle: mostly in range, sometimes a right angle, sometimes any 16 bits.
    function automatic logic signed [15:0] random_angle();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return 16'(int'($urandom_range(36000)) - 18000);
        else if (sel < 8)
            return 16'((int'($urandom_range(4)) - 2) * 9000);
        return 16'($urandom);
    endfunction

    // Pick a pose coordinate: full range, near the origin, or near a limit.
    function automatic logic signed [31:0] random_pose();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return 32'($urandom);
        else if (sel < 8)
            return 32'(int'($urandom_range(200000)) - 100000);
        else if (sel == 8)
            return 32'sh7FFF_FFFF - 32'($urandom_range(120000));
        return 32'sh8000_0000 + 32'($urandom_range(120000));
    endfunction

    task automatic add_random_point();
        logic [15:0] r;
        int          sel;
        sel = $urandom_range(9);
        if (sel == 0)
            r = 16'd0;
        else if (sel == 1)
            r = 16'hFFFF;
        else
            r = 16'($urandom);
        add_point(r, random_angle(), 16'($urandom), 16'($urandom), random_angle(),
                  random_pose(), random_pose());
    endtask

    task automatic report_mismatch(input string what, input int idx,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s at result %0d: got %0d expected %0d",
                 what, idx, $signed(got), $signed(want));
        error_count++;
    endtask

    // Driver: presents queued points and predicts each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid <= 1'b0;
        end
        else
        begin
            if (point_valid && point_ready)
            begin
                predicted_globals.push_back(transform_point(drive_pt));
                sent_points++;
            end
            if (!point_valid || point_ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct(1'b0))
                begin
                    drive_pt    <= pending_points.pop_front();
                    point_valid <= 1'b1;
                end
                else
                begin
                    point_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each returned transaction and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (predicted_globals.size() == 0)
                begin
                    report_mismatch("unexpected result", checked_points, global_x, 32'd0);
                end
                else
                begin
                    head_pt = predicted_globals.pop_front();
                    if (global_x !== head_pt.gx)
                        report_mismatch("global_x", checked_points, global_x, head_pt.gx);
                    if (global_y !== head_pt.gy)
                        report_mismatch("global_y", checked_points, global_y, head_pt.gy);
                end
                checked_points++;
            end
            result_ready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        rst_n = 1'b0;

        // Zero input, then longest range straight ahead.
        add_point(16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        add_point(16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        // Right angles and half turns on the beam and on the heading.
        add_point(16'd1000, 16'sd9000, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        add_point(16'd1000, -16'sd9000, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        add_point(16'd1000, 16'sd18000, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        add_point(16'd1000, -16'sd18000, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        add_point(16'd1000, 16'sd4500, 16'sd100, -16'sd100, 16'sd9000, 32'sd5, 32'sd7);
        add_point(16'd1000, 16'sd0, 16'sd250, 16'sd0, -16'sd9000, 32'sd0, 32'sd0);
        add_point(16'd1000, 16'sd0, 16'sd0, 16'sd250, 16'sd18000, 32'sd0, 32'sd0);
        add_point(16'd1000, 16'sd0, 16'sd0, 16'sd0, -16'sd18000, 32'sd0, 32'sd0);
        // Angles beyond a half turn wrap around.
        add_point(16'd3000, 16'sd27000, 16'sd0, 16'sd0, 16'sd32767, 32'sd0, 32'sd0);
        add_point(16'd3000, -16'sd32768, 16'sd0, 16'sd0, -16'sd27000, 32'sd0, 32'sd0);
        add_point(16'd3000, 16'sd32767, 16'sd0, 16'sd0, -16'sd32768, 32'sd0, 32'sd0);
        // Mounting offset extremes.
        add_point(16'hFFFF, 16'sd0, 16'sd32767, 16'sd32767, 16'sd4500, 32'sd0, 32'sd0);
        add_point(16'hFFFF, 16'sd18000, -16'sd32768, -16'sd32768, 16'sd0, 32'sd0, 32'sd0);
        // Saturation at both limits on each axis.
        add_point(16'hFFFF, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 32'sh7FFF_FFFF, 32'sd0);
        add_point(16'hFFFF, 16'sd18000, 16'sd0, 16'sd0, 16'sd0, 32'sh8000_0000, 32'sd0);
        add_point(16'hFFFF, 16'sd9000, 16'sd0, 16'sd32767, 16'sd0, 32'sd0, 32'sh7FFF_FFFF);
        add_point(16'hFFFF, -16'sd9000, 16'sd0, -16'sd32768, 16'sd0, 32'sd0, 32'sh8000_0000);
        add_point(16'hFFFF, 16'sd4500, 16'sd32767, 16'sd32767, 16'sd4500,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_point(16'hFFFF, 16'sd4500, -16'sd32768, -16'sd32768, -16'sd13500,
                  32'sh8000_0000, 32'sh8000_0000);
        directed_points = pending_points.size();

        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_random_point();
        total_points = pending_points.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all points to go in and all results to come back.
        while (pending_points.size() != 0 || point_valid)
            @(posedge clk);
        while (predicted_globals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        // Every queued point must have come back exactly once.
        if (checked_points != total_points)
            report_mismatch("result count", checked_points, checked_points, total_points);

        $display("Sent %0d points (%0d directed: right angles, wrap, mount extremes, saturation)",
                 sent_points, directed_points);
        $display("Checked %0d results under sender and receiver idling phases, %0d mismatches",
                 checked_points, error_count);
        if (error_count == 0)
            $display("[range_point_to_global_frame] OK");
        else
            $display("[range_point_to_global_frame] ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", predicted_globals.size());
        $display("[range_point_to_global_frame] ERROR");
        $finish;
    end

endmodule
